### rtl/mpq_pkg.sv
// shared types and codes for the min priority queue core
package mpq_pkg;

   localparam int KEY_W  = 23;
   localparam int ID_W   = 16;
   localparam int FARE_W = 20;
   localparam int PTS_W  = 16;
   localparam int STAT_W = 3;
   localparam int CNTO_W = 4;
   localparam int CSR_W  = 4;

   localparam logic [CSR_W-1:0] CAP_RESET = 4'd5;
   localparam int               POINT_SCALE = 200;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_LIST   = 2'd2;

   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_LISTED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [ID_W-1:0]   id;
      logic [FARE_W-1:0] fare;
      logic [PTS_W-1:0]  points;
   } entry_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_SHIFT  = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

endpackage

### rtl/min_priority_queue_core.sv
// min priority queue core: sorted chain of cells with command-style request port
//
//  channel   handshake            payload
//  request   start / busy         req_type, req_passenger_id, req_fare_cents, req_points
//  response  rsp_valid strobe     rsp_status, rsp_out_*, rsp_entry_count, rsp_last
//  csr       csr_we               csr_wdata (capacity limit)
//
// insert and remove: all cells shift or hold in the accept cycle and the result shows on
// the next cycle. a list shows the stored entries in key order, set by the chain rotating
// one slot per cycle past cell 0; busy stays high until the last entry.
// reset (synchronous) empties the queue and sets the limit to 5; slot contents are kept.
// the receiver cannot stall: each result is shown for exactly one cycle.
module min_priority_queue_core #(
   parameter int CAPACITY = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_type,
   input  logic [mpq_pkg::ID_W-1:0]    req_passenger_id,
   input  logic [mpq_pkg::FARE_W-1:0]  req_fare_cents,
   input  logic [mpq_pkg::PTS_W-1:0]   req_points,
   output logic                        rsp_valid,
   output logic [mpq_pkg::STAT_W-1:0]  rsp_status,
   output logic [mpq_pkg::ID_W-1:0]    rsp_out_id,
   output logic [mpq_pkg::FARE_W-1:0]  rsp_out_fare,
   output logic [mpq_pkg::PTS_W-1:0]   rsp_out_points,
   output logic [mpq_pkg::KEY_W-1:0]   rsp_out_key,
   output logic [mpq_pkg::CNTO_W-1:0]  rsp_entry_count,
   output logic                        rsp_last,
   input  logic                        csr_we,
   input  logic [mpq_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int LIM_W = (CNT_W > mpq_pkg::CSR_W) ? CNT_W : mpq_pkg::CSR_W;
   localparam logic [LIM_W-1:0] CAP_MAX = LIM_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [mpq_pkg::CSR_W-1:0] cap_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          left_ff, left_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [mpq_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   mpq_pkg::entry_type        rsp_entry_ff, rsp_entry_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;

   mpq_pkg::cell_ctrl_type ctrl;
   mpq_pkg::entry_type     cell_q [CAPACITY];
   logic                   cell_go [CAPACITY];
   mpq_pkg::entry_type     zero_entry;

   logic                   accept;
   logic                   full;
   logic [LIM_W-1:0]       cap_ext, limit;
   logic [mpq_pkg::KEY_W-1:0] new_key;
   logic [mpq_pkg::KEY_W:0]   point_part;

   assign accept  = start && !busy;
   assign busy    = left_ff != '0;
   assign cap_ext = LIM_W'(cap_ff);
   assign limit   = (cap_ext > CAP_MAX) ? CAP_MAX : cap_ext;
   assign full    = LIM_W'(count_ff) >= limit;

   assign point_part = (mpq_pkg::KEY_W + 1)'(req_points >> 1) * (mpq_pkg::KEY_W + 1)'(mpq_pkg::POINT_SCALE);
   assign new_key    = mpq_pkg::KEY_W'(point_part + (mpq_pkg::KEY_W + 1)'(req_fare_cents));

   assign zero_entry = '0;

   always_comb begin
      ctrl.new_entry.key    = new_key;
      ctrl.new_entry.id     = req_passenger_id;
      ctrl.new_entry.fare   = req_fare_cents;
      ctrl.new_entry.points = req_points;
      ctrl.op       = mpq_pkg::OP_HOLD;
      count_in      = count_ff;
      left_in       = left_ff;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b1;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = zero_entry;
      rsp_count_in  = count_ff;
      if (busy) begin
         // list in progress: head is the next entry in key order
         ctrl.op       = mpq_pkg::OP_ROTATE;
         left_in       = left_ff - CNT_ONE;
         rsp_valid_in  = 1'b1;
         rsp_status_in = mpq_pkg::ST_LISTED;
         rsp_entry_in  = cell_q[0];
         rsp_last_in   = left_ff == CNT_ONE;
      end else if (accept) begin
         case (req_type)
            mpq_pkg::REQ_INSERT: begin
               rsp_valid_in = 1'b1;
               if (full) begin
                  rsp_status_in = mpq_pkg::ST_FULL;
               end else begin
                  ctrl.op       = mpq_pkg::OP_INSERT;
                  count_in      = count_ff + CNT_ONE;
                  rsp_count_in  = count_ff + CNT_ONE;
                  rsp_status_in = mpq_pkg::ST_INSERTED;
               end
            end
            mpq_pkg::REQ_REMOVE: begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_status_in = mpq_pkg::ST_EMPTY;
               end else begin
                  ctrl.op       = mpq_pkg::OP_SHIFT;
                  count_in      = count_ff - CNT_ONE;
                  rsp_count_in  = count_ff - CNT_ONE;
                  rsp_status_in = mpq_pkg::ST_REMOVED;
                  rsp_entry_in  = cell_q[0];
               end
            end
            mpq_pkg::REQ_LIST: begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_status_in = mpq_pkg::ST_EMPTY;
               end else begin
                  ctrl.op       = mpq_pkg::OP_ROTATE;
                  left_in       = count_ff - CNT_ONE;
                  rsp_status_in = mpq_pkg::ST_LISTED;
                  rsp_entry_in  = cell_q[0];
                  rsp_last_in   = count_ff == CNT_ONE;
               end
            end
            default: begin
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      mpq_pkg::entry_type left_e, right_e;
      logic               left_g;
      if (i == 0) begin : g_first
         assign left_e = cell_q[0];
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_e = cell_q[i-1];
         assign left_g = cell_go[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_e = cell_q[i];
      end else begin : g_inner
         assign right_e = cell_q[i+1];
      end
      mpq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .count       (count_ff),
         .left_entry  (left_e),
         .left_go     (left_g),
         .right_entry (right_e),
         .head_entry  (cell_q[0]),
         .go          (cell_go[i]),
         .entry       (cell_q[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= mpq_pkg::CAP_RESET;
         count_ff     <= '0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_id      = rsp_entry_ff.id;
   assign rsp_out_fare    = rsp_entry_ff.fare;
   assign rsp_out_points  = rsp_entry_ff.points;
   assign rsp_out_key     = rsp_entry_ff.key;
   assign rsp_entry_count = mpq_pkg::CNTO_W'(rsp_count_ff);
   assign rsp_last        = rsp_last_ff;

   // a list never runs past the stored entries
   a_busy_le_count: assert property (@(posedge clock) disable iff (reset)
      busy |-> (left_ff < count_ff))
      else $error("list countdown exceeds stored count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("stored count above capacity");

   // while listing, each cycle emits a listed entry and the count stays put
   a_list_emits: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && rsp_status == mpq_pkg::ST_LISTED && $stable(count_ff)))
      else $error("list cycle without listed transaction");

   a_last_ends_list: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mpq_pkg::ST_LISTED && !rsp_last) |-> busy)
      else $error("list ended before last transaction");

endmodule

### rtl/mpq_cell.sv
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module mpq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 4
) (
   input  logic                   clock,
   input  mpq_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]       count,
   input  mpq_pkg::entry_type     left_entry,
   input  logic                   left_go,
   input  mpq_pkg::entry_type     right_entry,
   input  mpq_pkg::entry_type     head_entry,
   output logic                   go,
   output mpq_pkg::entry_type     entry
);

   mpq_pkg::entry_type entry_ff, entry_in;
   logic slot_valid, wrap;

   assign slot_valid = CNT_W'(INDEX) < count;
   assign wrap       = CNT_W'(INDEX + 1) >= count;
   // this slot and everything to its right moves over for the new entry
   assign go = !slot_valid || (entry_ff.key > ctrl.new_entry.key);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         mpq_pkg::OP_INSERT: begin
            if (left_go) begin
               entry_in = left_entry;
            end else if (go) begin
               entry_in = ctrl.new_entry;
            end
         end
         mpq_pkg::OP_SHIFT: begin
            entry_in = right_entry;
         end
         mpq_pkg::OP_ROTATE: begin
            // last stored slot refills from the head so a full pass restores order
            entry_in = wrap ? head_entry : right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
